// ===== sv/sll_pkg.sv =====
package sll_pkg;

  localparam int DefaultDepth = 32;

  localparam int FuncW   = 2;
  localparam int PosW    = 6;
  localparam int ValueW  = 32;
  localparam int StatusW = 3;
  localparam int OutPosW = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic link_we;
    logic value_we;
  } wr_en_t;

endpackage

// ===== sv/sll_in_if.sv =====
interface sll_in_if;
  logic                                valid;
  logic                                ready;
  logic        [sll_pkg::FuncW-1:0]    func;
  logic        [sll_pkg::PosW-1:0]     pos;
  logic signed [sll_pkg::ValueW-1:0]   value;

  modport source (output valid, output func, output pos, output value, input ready);
  modport sink   (input valid, input func, input pos, input value, output ready);
endinterface

// ===== sv/sll_out_if.sv =====
interface sll_out_if;
  logic                          valid;
  logic                          ready;
  logic [sll_pkg::StatusW-1:0]   status;
  logic [sll_pkg::OutPosW-1:0]   found_pos;
  logic [sll_pkg::OutPosW-1:0]   list_length;

  modport source (output valid, output status, output found_pos, output list_length,
                  input ready);
  modport sink   (input valid, input status, input found_pos, input list_length,
                  output ready);
endinterface

// ===== sv/sll_store.sv =====
module sll_store #(
  parameter int DEPTH = sll_pkg::DefaultDepth
) (
  input  logic                               clk_i,
  input  sll_pkg::wr_en_t                    we_i,
  input  logic [$clog2(DEPTH)-1:0]           waddr_i,
  input  logic [$clog2(DEPTH+1)-1:0]         wlink_i,
  input  logic signed [sll_pkg::ValueW-1:0]  wvalue_i,
  input  logic [$clog2(DEPTH)-1:0]           raddr_i,
  output logic [$clog2(DEPTH+1)-1:0]         rlink_o,
  output logic signed [sll_pkg::ValueW-1:0]  rvalue_o
);

  localparam int LinkW = $clog2(DEPTH + 1);

  logic [LinkW-1:0]                  link_mem  [DEPTH];
  logic signed [sll_pkg::ValueW-1:0] value_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i.link_we) begin
      link_mem[waddr_i] <= wlink_i;
    end
    rlink_o <= link_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.value_we) begin
      value_mem[waddr_i] <= wvalue_i;
    end
    rvalue_o <= value_mem[raddr_i];
  end

endmodule

// ===== sv/static_linked_list_engine.sv =====
// Steps: an insert scans for a free entry, walks toward pos, writes the new node, then relinks
//   its predecessor; a remove walks, relinks, then frees the entry; a find walks comparing values.
// Flow: one item at a time; each step of the scan or the walk is one read of the
//   link store's single read port.
// Reset: asynchronous, active low; a clearing pass then rewrites the link
//   store (head to end, all others free) and the input stays not ready until it finishes.
module static_linked_list_engine #(
  parameter int DEPTH = sll_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sll_in_if.sink    in_i,
  sll_out_if.source out_o
);

  localparam int IdxW  = $clog2(DEPTH);
  localparam int LinkW = $clog2(DEPTH + 1);
  localparam int CntW  = $clog2(DEPTH);
  localparam int WalkW = (IdxW > sll_pkg::PosW) ? IdxW : sll_pkg::PosW;

  localparam logic [LinkW-1:0] EndCode  = '0;
  localparam logic [LinkW-1:0] FreeCode = LinkW'(DEPTH);

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_SCAN      = 11'b000_0000_0100,
    S_WALK      = 11'b000_0000_1000,
    S_INS_NODE  = 11'b000_0001_0000,
    S_INS_LINK  = 11'b000_0010_0000,
    S_RM_LINK   = 11'b000_0100_0000,
    S_RM_FREE   = 11'b000_1000_0000,
    S_FIND_HEAD = 11'b001_0000_0000,
    S_FIND      = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_e;

  function automatic logic [LinkW-1:0] succ_of(logic [LinkW-1:0] lnk);
    return (lnk >= FreeCode) ? EndCode : lnk;
  endfunction

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q, out_valid_d;

  sll_pkg::func_e                    func_q, func_d;
  logic [sll_pkg::PosW-1:0]          pos_q, pos_d;
  logic signed [sll_pkg::ValueW-1:0] value_q, value_d;
  logic [IdxW-1:0]                   cur_q, cur_d;
  logic [WalkW-1:0]                  cnt_q, cnt_d;
  logic [LinkW-1:0]                  nxt_q, nxt_d;
  sll_pkg::status_e                  res_status_q, res_status_d;
  logic [sll_pkg::OutPosW-1:0]       res_pos_q, res_pos_d;
  sll_pkg::status_e                  out_status_q, out_status_d;
  logic [sll_pkg::OutPosW-1:0]       out_pos_q, out_pos_d;
  logic [sll_pkg::OutPosW-1:0]       out_len_q, out_len_d;

  sll_pkg::wr_en_t                   we;
  logic [IdxW-1:0]                   waddr;
  logic [LinkW-1:0]                  wlink;
  logic signed [sll_pkg::ValueW-1:0] wvalue;
  logic [IdxW-1:0]                   rd_addr;
  logic [LinkW-1:0]                  rd_link;
  logic signed [sll_pkg::ValueW-1:0] rd_value;
  logic [LinkW-1:0]                  rd_next;
  sll_pkg::func_e                    in_func;
  logic                              pos_bad;
  logic                              full;

  sll_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wlink_i  (wlink),
    .wvalue_i (wvalue),
    .raddr_i  (rd_addr),
    .rlink_o  (rd_link),
    .rvalue_o (rd_value)
  );

  assign in_func = sll_pkg::func_e'(in_i.func);
  assign pos_bad = 32'(in_i.pos) > 32'(DEPTH);
  assign full    = count_q == CntW'(DEPTH - 1);
  assign rd_next = succ_of(rd_link);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    func_d       = func_q;
    pos_d        = pos_q;
    value_d      = value_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    nxt_d        = nxt_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_len_d    = out_len_q;
    we           = '0;
    waddr        = idx_q;
    wlink        = nxt_q;
    wvalue       = value_q;
    rd_addr      = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        we.link_we = 1'b1;
        wlink      = (idx_q == '0) ? EndCode : FreeCode;
        idx_d      = idx_q + IdxW'(1);
        if (idx_q == IdxW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = (in_func == sll_pkg::FUNC_INSERT) ? IdxW'(1) : '0;
        if (in_i.valid) begin
          func_d    = in_func;
          pos_d     = in_i.pos;
          value_d   = in_i.value;
          cur_d     = '0;
          cnt_d     = '0;
          idx_d     = IdxW'(1);
          res_pos_d = '0;
          case (in_func)
            sll_pkg::FUNC_INSERT: begin
              if (pos_bad) begin
                res_status_d = sll_pkg::ST_BADPOS;
                state_d      = S_DONE;
              end else if (full) begin
                res_status_d = sll_pkg::ST_FULL;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            sll_pkg::FUNC_REMOVE: begin
              if (pos_bad) begin
                res_status_d = sll_pkg::ST_BADPOS;
                state_d      = S_DONE;
              end else begin
                state_d = S_WALK;
              end
            end
            sll_pkg::FUNC_FIND: begin
              state_d = S_FIND_HEAD;
            end
            default: begin
              res_status_d = sll_pkg::ST_BADPOS;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_link == FreeCode) begin
          rd_addr = '0;
          state_d = S_WALK;
        end else begin
          rd_addr = idx_q + IdxW'(1);
          idx_d   = idx_q + IdxW'(1);
        end
      end
      S_WALK: begin
        rd_addr = IdxW'(rd_next);
        if (cnt_q == WalkW'(pos_q) || rd_next == EndCode) begin
          nxt_d = rd_next;
          if (func_q == sll_pkg::FUNC_INSERT) begin
            state_d = S_INS_NODE;
          end else if (rd_next == EndCode) begin
            res_status_d = sll_pkg::ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            state_d = S_RM_LINK;
          end
        end else begin
          cur_d = IdxW'(rd_next);
          cnt_d = cnt_q + WalkW'(1);
        end
      end
      S_INS_NODE: begin
        we.link_we  = 1'b1;
        we.value_we = 1'b1;
        waddr       = idx_q;
        wlink       = nxt_q;
        wvalue      = value_q;
        state_d     = S_INS_LINK;
      end
      S_INS_LINK: begin
        we.link_we   = 1'b1;
        waddr        = cur_q;
        wlink        = LinkW'(idx_q);
        count_d      = count_q + CntW'(1);
        res_status_d = sll_pkg::ST_OK;
        state_d      = S_DONE;
      end
      S_RM_LINK: begin
        we.link_we = 1'b1;
        waddr      = cur_q;
        wlink      = rd_next;
        state_d    = S_RM_FREE;
      end
      S_RM_FREE: begin
        we.link_we   = 1'b1;
        waddr        = IdxW'(nxt_q);
        wlink        = FreeCode;
        count_d      = count_q - CntW'(1);
        res_status_d = sll_pkg::ST_OK;
        state_d      = S_DONE;
      end
      S_FIND_HEAD: begin
        rd_addr = IdxW'(rd_next);
        if (rd_next == EndCode) begin
          res_status_d = sll_pkg::ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        rd_addr = IdxW'(rd_next);
        if (rd_value == value_q) begin
          res_status_d = sll_pkg::ST_OK;
          res_pos_d    = sll_pkg::OutPosW'(cnt_q);
          state_d      = S_DONE;
        end else if (rd_next == EndCode) begin
          res_status_d = sll_pkg::ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          cnt_d = cnt_q + WalkW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = res_pos_q;
          out_len_d    = sll_pkg::OutPosW'(32'(count_q));
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    pos_q        <= pos_d;
    value_q      <= value_d;
    cur_q        <= cur_d;
    cnt_q        <= cnt_d;
    nxt_q        <= nxt_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_len_q    <= out_len_d;
  end

  assign in_i.ready        = state_q == S_IDLE;
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found_pos   = out_pos_q;
  assign out_o.list_length = out_len_q;

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_LINK |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the entry count");

  a_rm_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RM_FREE |=> count_q == $past(count_q) - CntW'(1))
    else $error("remove did not shrink the entry count");

  a_scan_not_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q != '0)
    else $error("free-entry scan reached the head");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

endmodule
